// ===== sv/psrl_pkg.sv =====
// Shared types and codes for the priority-sorted render list.
// Used by psrl_ctrl, psrl_datapath and the top level; no dependencies.
package psrl_pkg;

    // Input command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // Result kinds
    localparam logic [2:0] K_DONE  = 3'd0;
    localparam logic [2:0] K_FULL  = 3'd1;
    localparam logic [2:0] K_SELF  = 3'd2;
    localparam logic [2:0] K_ENTRY = 3'd3;
    localparam logic [2:0] K_EMPTY = 3'd4;

    // Configuration register indexes
    localparam logic REG_LIST_ENABLED = 1'b0;
    localparam logic REG_OWN_HANDLE   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       insert_en;  // write the new entry into the shift cells
        logic       clear_en;   // empty the list
        logic       list_load;  // capture the mask of listable slots
        logic       rotate;     // rotate slots and mask by one place
        logic       out_load;   // load the output register
        logic [2:0] out_kind;   // kind to load
    } psrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] insert_kind; // outcome an insert would have
        logic       list_empty;  // nothing to list for a list command
        logic       mask_head;   // slot at the head is still to be listed
    } psrl_status_t;

endpackage

// ===== sv/psrl_datapath.sv =====
// Datapath of the render list: shift-cell slot array, listing mask and
// output register. Depends on psrl_pkg for command/status types and codes.
module psrl_datapath #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  psrl_pkg::psrl_cmd_t     cmd,
    output psrl_pkg::psrl_status_t  status,
    input  logic                    list_enabled,
    input  logic [15:0]             own_handle,
    input  logic [15:0]             handle,
    input  logic signed [15:0]      priority_req,
    input  logic                    object_active,
    output logic [2:0]              kind,
    output logic [15:0]             out_handle,
    output logic signed [15:0]      out_priority,
    output logic                    last
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [15:0]        slot_handle_reg   [LIST_DEPTH];
    logic [15:0]        slot_handle_next  [LIST_DEPTH];
    logic signed [15:0] slot_priority_reg [LIST_DEPTH];
    logic signed [15:0] slot_priority_next[LIST_DEPTH];
    logic [LIST_DEPTH-1:0] slot_active_reg, slot_active_next;
    logic [LIST_DEPTH-1:0] mask_reg, mask_next;
    logic [CW-1:0]         count_reg, count_next;

    logic [LIST_DEPTH-1:0] in_use;
    logic [LIST_DEPTH-1:0] gt;
    logic [LIST_DEPTH-1:0] gt_prev;
    logic [LIST_DEPTH-1:0] at_count;
    logic [LIST_DEPTH-1:0] live_mask;

    logic [2:0]         kind_reg;
    logic [15:0]        out_handle_reg;
    logic signed [15:0] out_priority_reg;
    logic               last_reg;

    // Per-cell compares: occupied, and holding a higher priority than the request
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            in_use[i]   = CW'(i) < count_reg;
            at_count[i] = CW'(i) == count_reg;
            gt[i]       = in_use[i] && (slot_priority_reg[i] > priority_req);
        end
        gt_prev   = {gt[LIST_DEPTH-2:0], 1'b0};
        live_mask = list_enabled ? (slot_active_reg & in_use) : '0;
    end

    // Status back to the controller
    always_comb
    begin
        priority if (handle == own_handle)
            status.insert_kind = psrl_pkg::K_SELF;
        else if (count_reg == CW'(LIST_DEPTH))
            status.insert_kind = psrl_pkg::K_FULL;
        else
            status.insert_kind = psrl_pkg::K_DONE;
        status.list_empty = (live_mask == '0);
        status.mask_head  = mask_reg[0];
    end

    // Slot cells: shift up behind the insert point, or rotate while listing
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            slot_handle_next[i]   = slot_handle_reg[i];
            slot_priority_next[i] = slot_priority_reg[i];
            slot_active_next[i]   = slot_active_reg[i];
            if (cmd.rotate)
            begin
                slot_handle_next[i]   = slot_handle_reg[(i == LIST_DEPTH-1) ? 0 : i+1];
                slot_priority_next[i] = slot_priority_reg[(i == LIST_DEPTH-1) ? 0 : i+1];
                slot_active_next[i]   = slot_active_reg[(i == LIST_DEPTH-1) ? 0 : i+1];
            end
            else if (cmd.insert_en)
            begin
                if (gt_prev[i])
                begin
                    slot_handle_next[i]   = slot_handle_reg[(i == 0) ? 0 : i-1];
                    slot_priority_next[i] = slot_priority_reg[(i == 0) ? 0 : i-1];
                    slot_active_next[i]   = slot_active_reg[(i == 0) ? 0 : i-1];
                end
                else if (gt[i] || at_count[i])
                begin
                    slot_handle_next[i]   = handle;
                    slot_priority_next[i] = priority_req;
                    slot_active_next[i]   = object_active;
                end
            end
        end
    end

    // Entry count and listing mask
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_en)
            count_next = '0;
        else if (cmd.insert_en)
            count_next = count_reg + CW'(1);

        mask_next = mask_reg;
        if (cmd.list_load)
            mask_next = live_mask;
        else if (cmd.rotate)
            mask_next = mask_reg >> 1;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            slot_handle_reg[i]   <= slot_handle_next[i];
            slot_priority_reg[i] <= slot_priority_next[i];
        end
        slot_active_reg <= slot_active_next;
        mask_reg        <= mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Output register; an entry is last when no listable slot remains behind it
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg <= cmd.out_kind;
            if (cmd.out_kind == psrl_pkg::K_ENTRY)
            begin
                out_handle_reg   <= slot_handle_reg[0];
                out_priority_reg <= slot_priority_reg[0];
                last_reg         <= (mask_reg[LIST_DEPTH-1:1] == '0);
            end
            else
            begin
                out_handle_reg   <= '0;
                out_priority_reg <= '0;
                last_reg         <= 1'b1;
            end
        end
    end

    assign kind         = kind_reg;
    assign out_handle   = out_handle_reg;
    assign out_priority = out_priority_reg;
    assign last         = last_reg;

endmodule

// ===== sv/psrl_ctrl.sv =====
// Controller of the render list: command decode, listing sequencer and
// output handshake. Depends on psrl_pkg for command/status types and codes.
module psrl_ctrl #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             command,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  psrl_pkg::psrl_status_t status,
    output psrl_pkg::psrl_cmd_t    cmd,
    output logic                   busy
);

    localparam int IW = $clog2(LIST_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic          state_reg, state_next;
    logic [IW-1:0] rot_reg, rot_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;
    logic          in_xfer;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = in_valid && in_ready;
    assign busy     = (state_reg == ST_LIST);

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        rot_next   = rot_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.out_load = 1'b1;
                    unique case (command)
                        psrl_pkg::CMD_INSERT:
                        begin
                            cmd.out_kind  = status.insert_kind;
                            cmd.insert_en = (status.insert_kind == psrl_pkg::K_DONE);
                        end
                        psrl_pkg::CMD_CLEAR:
                        begin
                            cmd.out_kind = psrl_pkg::K_DONE;
                            cmd.clear_en = 1'b1;
                        end
                        psrl_pkg::CMD_LIST:
                        begin
                            if (status.list_empty)
                                cmd.out_kind = psrl_pkg::K_EMPTY;
                            else
                            begin
                                cmd.out_load  = 1'b0;
                                cmd.list_load = 1'b1;
                                state_next    = ST_LIST;
                                rot_next      = '0;
                            end
                        end
                        default:
                            cmd.out_kind = psrl_pkg::K_DONE;
                    endcase
                end
            end
            ST_LIST:
            begin
                // Hold while the head entry waits for a free output register
                if (!(status.mask_head && !out_free))
                begin
                    cmd.rotate = 1'b1;
                    if (status.mask_head)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = psrl_pkg::K_ENTRY;
                    end
                    rot_next = rot_reg + IW'(1);
                    if (rot_reg == IW'(LIST_DEPTH - 1))
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/priority_sorted_render_list.sv =====
// Priority-sorted render list: stable ascending list of handles by priority.
// Insert, clear: result registered and shown the next cycle.
// List: accept, then one full rotation of the slot cells (head slot read at
// each step), held while the output is stalled; an empty list answers the
// next cycle. Reset clears count, control and config
// (list_enabled = 1, own_handle = 0); slot contents are left undefined.
module priority_sorted_render_list #(
    parameter int LIST_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [15:0]        handle,
    input  logic signed [15:0] priority_req,
    input  logic               object_active,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic [15:0]        out_handle,
    output logic signed [15:0] out_priority,
    output logic               last
);

    logic        list_enabled_reg, list_enabled_next;
    logic [15:0] own_handle_reg, own_handle_next;
    logic        cfg_wr;
    logic        busy;

    psrl_pkg::psrl_cmd_t    cmd;
    psrl_pkg::psrl_status_t status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        list_enabled_next = list_enabled_reg;
        own_handle_next   = own_handle_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                psrl_pkg::REG_LIST_ENABLED: list_enabled_next = pwdata[0];
                psrl_pkg::REG_OWN_HANDLE:   own_handle_next   = pwdata[15:0];
                default:                    list_enabled_next = list_enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_enabled_reg <= 1'b1;
            own_handle_reg   <= '0;
        end
        else
        begin
            list_enabled_reg <= list_enabled_next;
            own_handle_reg   <= own_handle_next;
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            psrl_pkg::REG_LIST_ENABLED: prdata = {31'd0, list_enabled_reg};
            psrl_pkg::REG_OWN_HANDLE:   prdata = {16'd0, own_handle_reg};
            default:                    prdata = '0;
        endcase
    end

    psrl_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    psrl_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .list_enabled  (list_enabled_reg),
        .own_handle    (own_handle_reg),
        .handle        (handle),
        .priority_req  (priority_req),
        .object_active (object_active),
        .kind          (kind),
        .out_handle    (out_handle),
        .out_priority  (out_priority),
        .last          (last)
    );

    // No new transfer is taken while a listing is in progress
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("input taken during listing");

    // A self insert answers with the rejected kind in the next cycle
    a_self_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == psrl_pkg::CMD_INSERT &&
         handle == own_handle_reg) |=> (out_valid && kind == psrl_pkg::K_SELF))
        else $error("self insert not rejected");

    // Results other than listed entries carry zero payload and end the item
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != psrl_pkg::K_ENTRY) |->
        (out_handle == 16'd0 && out_priority == 16'sd0 && last))
        else $error("non-entry result malformed");

endmodule
